/* sv/ffrc_pkg.sv */
package ffrc_pkg;

  // Frame layout
  localparam logic [7:0] HDR0      = 8'hAA;
  localparam logic [7:0] HDR1      = 8'h55;
  localparam logic [7:0] BYTE_MASK = 8'hFF;
  localparam int unsigned CMD_POS  = 4;
  localparam int unsigned LEN_POS  = 6;
  localparam int unsigned PAY_POS  = 8;

  // At most this many payload results per frame
  localparam int unsigned MAX_OUT = 16;

  // Frame queue between front and back; one payload bank per slot
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic bank_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_ERR  = 2'd1,
    ST_SUM_ERR  = 2'd2,
    ST_CLAMPED  = 2'd3
  } status_e;

  // One finished frame, as handed from front to back
  typedef struct packed {
    status_e     status;
    logic [7:0]  command;
    logic [4:0]  length;
    logic [4:0]  n_bytes;
  } frame_desc_t;

endpackage

/* sv/fixed_frame_receive_checker.sv */
// Fixed-length frame receive checker.
// Input channel (in_valid_i / in_stall_o): one received word per cycle
// while not stalled, rx_byte_i with frame_start_i marking word 0 of a frame;
// a start flag drops any partial frame. The front part sums and checks each
// frame and, on its last word, places one descriptor into a two-entry frame
// queue; each queue slot owns one bank of the payload store.
// Output channel (out_valid_o / out_stall_i): one result word per cycle
// from the back part while not stalled. A header or checksum failure gives
// a single word with status set; a good frame gives one word per payload
// byte (at most 16), or one word without a byte when the length is zero.
// last_o closes each frame. Once a frame's last word is accepted, its first
// result passes the queue entry, the s1 register and the output register.
// While the receiver stalls, the output register holds; once two checked
// frames are waiting, in_stall_o rises until the back part frees a slot.
// Reset clears the position, sum and queue; payload store contents are left
// as they are, and no clearing pass is needed.
module fixed_frame_receive_checker
  import ffrc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 26,
  parameter int unsigned PAYLOAD_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] command_o,
  output logic [4:0] payload_length_o,
  output logic [7:0] payload_byte_o,
  output logic [3:0] payload_index_o,
  output logic       byte_present_o,
  output logic       last_o
);

  localparam int unsigned STORE_DEPTH = (PAYLOAD_MAX < MAX_OUT) ? PAYLOAD_MAX : MAX_OUT;
  localparam int unsigned STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                push, pop, full, head_valid;
  frame_desc_t         desc, head;
  bank_t               wr_bank, rd_bank, st_wr_bank;
  logic                st_wr_en;
  logic [STORE_AW-1:0] st_wr_addr;
  logic [7:0]          st_wr_data;

  ffrc_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .PAYLOAD_MAX (PAYLOAD_MAX),
    .STORE_DEPTH (STORE_DEPTH),
    .STORE_AW    (STORE_AW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .full_i        (full),
    .wr_bank_i     (wr_bank),
    .push_o        (push),
    .desc_o        (desc),
    .st_wr_en_o    (st_wr_en),
    .st_wr_bank_o  (st_wr_bank),
    .st_wr_addr_o  (st_wr_addr),
    .st_wr_data_o  (st_wr_data)
  );

  ffrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .wr_bank_o    (wr_bank),
    .rd_bank_o    (rd_bank)
  );

  ffrc_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .STORE_AW    (STORE_AW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .rd_bank_i        (rd_bank),
    .pop_o            (pop),
    .st_wr_en_i       (st_wr_en),
    .st_wr_bank_i     (st_wr_bank),
    .st_wr_addr_i     (st_wr_addr),
    .st_wr_data_i     (st_wr_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .byte_present_o   (byte_present_o),
    .last_o           (last_o)
  );

endmodule

/* sv/ffrc_front.sv */
module ffrc_front
  import ffrc_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 26,
  parameter int unsigned PAYLOAD_MAX = 16,
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned STORE_AW    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  input  logic                full_i,
  input  bank_t               wr_bank_i,
  output logic                push_o,
  output frame_desc_t         desc_o,
  output logic                st_wr_en_o,
  output bank_t               st_wr_bank_o,
  output logic [STORE_AW-1:0] st_wr_addr_o,
  output logic [7:0]          st_wr_data_o
);

  localparam int unsigned PW = $clog2(FRAME_BYTES);

  logic [PW-1:0] pos_q, pos_d, pos, off;
  logic [15:0]   sum_q, sum_d;
  logic          hok_q, hok_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [7:0]    len_q, len_d;
  logic          slm_q, slm_d;
  logic          accept;
  logic          at_end;
  logic [7:0]    len_c;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Realign on a start flag
  assign pos    = frame_start_i ? '0 : pos_q;
  assign off    = pos - PW'(PAY_POS);
  assign at_end = (pos == PW'(FRAME_BYTES - 1));

  // Track header, sum and saved fields
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    hok_d = hok_q;
    cmd_d = cmd_q;
    len_d = len_q;
    slm_d = slm_q;
    if (accept) begin
      pos_d = at_end ? '0 : pos + PW'(1);
      if (pos == '0) begin
        hok_d = (rx_byte_i == HDR0);
        sum_d = {8'h00, rx_byte_i};
      end else begin
        if (pos == PW'(1)) begin
          hok_d = hok_q && (rx_byte_i == HDR1);
        end
        if (pos < PW'(FRAME_BYTES - 2)) begin
          sum_d = sum_q + {8'h00, rx_byte_i};
        end
      end
      if (pos == PW'(CMD_POS)) begin
        cmd_d = rx_byte_i;
      end
      if (pos == PW'(LEN_POS)) begin
        len_d = rx_byte_i;
      end
      if (pos == PW'(FRAME_BYTES - 2)) begin
        slm_d = (rx_byte_i == sum_q[7:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      hok_q <= 1'b0;
      cmd_q <= '0;
      len_q <= '0;
      slm_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      hok_q <= hok_d;
      cmd_q <= cmd_d;
      len_q <= len_d;
      slm_q <= slm_d;
    end
  end

  // Write payload words into the bank of the frame in progress
  assign st_wr_en_o   = accept && (pos >= PW'(PAY_POS))
                        && ({1'b0, off} < (PW + 1)'(STORE_DEPTH));
  assign st_wr_bank_o = wr_bank_i;
  assign st_wr_addr_o = off[STORE_AW-1:0];
  assign st_wr_data_o = rx_byte_i;

  // Classify the frame on its last word
  assign push_o = accept && at_end;
  assign len_c  = (len_q > 8'(PAYLOAD_MAX)) ? 8'(PAYLOAD_MAX) : len_q;

  always_comb begin
    desc_o = '0;
    priority if (!hok_q) begin
      desc_o.status = ST_HDR_ERR;
    end else if (!slm_q || (rx_byte_i != sum_q[15:8])) begin
      desc_o.status = ST_SUM_ERR;
    end else begin
      desc_o.status  = (len_q > 8'(PAYLOAD_MAX)) ? ST_CLAMPED : ST_OK;
      desc_o.command = cmd_q;
      desc_o.length  = len_c[4:0];
      desc_o.n_bytes = (len_c > 8'(MAX_OUT)) ? 5'(MAX_OUT) : len_c[4:0];
    end
  end

endmodule

/* sv/ffrc_queue.sv */
module ffrc_queue
  import ffrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  frame_desc_t desc_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        head_valid_o,
  output frame_desc_t head_o,
  output bank_t       wr_bank_o,
  output bank_t       rd_bank_o
);

  frame_desc_t entry_q [QUEUE_DEPTH];
  bank_t       wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o       = (count_q == 2'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = entry_q[rd_ptr_q];
  assign wr_bank_o    = wr_ptr_q;
  assign rd_bank_o    = rd_ptr_q;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Hold descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("frame pushed into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_valid_o))
    else $error("frame popped from empty queue");

  a_ptr_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || full_o) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with fill count");

endmodule

/* sv/ffrc_back.sv */
module ffrc_back
  import ffrc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16,
  parameter int unsigned STORE_AW    = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  frame_desc_t         head_i,
  input  bank_t               rd_bank_i,
  output logic                pop_o,
  input  logic                st_wr_en_i,
  input  bank_t               st_wr_bank_i,
  input  logic [STORE_AW-1:0] st_wr_addr_i,
  input  logic [7:0]          st_wr_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [7:0]          command_o,
  output logic [4:0]          payload_length_o,
  output logic [7:0]          payload_byte_o,
  output logic [3:0]          payload_index_o,
  output logic                byte_present_o,
  output logic                last_o
);

  logic [7:0] store_q [QUEUE_DEPTH][STORE_DEPTH];
  logic [7:0] rdata_q;

  logic [3:0] k_q;
  logic       s1_valid_q, out_valid_q;
  status_e    s1_status_q;
  logic [7:0] s1_command_q;
  logic [4:0] s1_length_q;
  logic [3:0] s1_index_q;
  logic       s1_present_q, s1_last_q;

  logic       out_load, s1_free, issue, is_last, has_bytes;

  assign has_bytes = (head_i.n_bytes != 5'd0);
  assign is_last   = !has_bytes || ({1'b0, k_q} == head_i.n_bytes - 5'd1);
  assign out_load  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free   = !s1_valid_q || out_load;
  assign issue     = head_valid_i && s1_free;
  assign pop_o     = issue && is_last;

  // Payload banks: written by the front, read one word per result with a byte
  always_ff @(posedge clk_i) begin
    if (st_wr_en_i) begin
      store_q[st_wr_bank_i][st_wr_addr_i] <= st_wr_data_i;
    end
    if (issue && has_bytes) begin
      rdata_q <= store_q[rd_bank_i][k_q[STORE_AW-1:0]];
    end
  end

  // Step through the results of the head frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        k_q <= is_last ? 4'd0 : k_q + 4'd1;
      end
      if (s1_free) begin
        s1_valid_q <= issue;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Carry result fields alongside the read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_status_q  <= head_i.status;
      s1_command_q <= head_i.command;
      s1_length_q  <= head_i.length;
      s1_index_q   <= has_bytes ? k_q : 4'd0;
      s1_present_q <= has_bytes;
      s1_last_q    <= is_last;
    end
  end

  // Output register; hold while stalled
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_o         <= s1_status_q;
      command_o        <= s1_command_q;
      payload_length_o <= s1_length_q;
      payload_byte_o   <= s1_present_q ? rdata_q : 8'h00;
      payload_index_o  <= s1_index_q;
      byte_present_o   <= s1_present_q;
      last_o           <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_k_needs_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 4'd0) |-> head_valid_i)
    else $error("result counter runs without a frame");

  a_error_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_HDR_ERR || status_o == ST_SUM_ERR))
      |-> (last_o && !byte_present_o))
    else $error("error result is not a single final word");

  a_pop_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (k_q == 4'd0))
    else $error("result counter not cleared after frame");

endmodule

/* bench/fixed_frame_receive_checker_tb.sv */
module fixed_frame_receive_checker_tb;
  import ffrc_pkg::*;

  localparam int unsigned FRAME_BYTES = 26;
  localparam int unsigned PAYLOAD_MAX = 16;
  localparam int unsigned RANDOM_BYTES = 30;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 20;

  // One result word as seen on the output channel
  typedef struct {
    status_e    status;
    logic [7:0] command;
    logic [4:0] length;
    logic [7:0] data;
    logic [3:0] index;
    logic       present;
    logic       closes;
  } result_t;

  // Frame tracker: follows the byte stream and queues the words each frame should yield
  class frame_result_board;
    int unsigned frame_pos;
    logic [15:0] byte_sum;
    bit          hdr_good;
    bit          low_sum_good;
    logic [7:0]  cmd_byte;
    logic [7:0]  len_byte;
    logic [7:0]  payload_bytes [PAYLOAD_MAX];
    result_t     awaited_results [$];
    int unsigned mismatches;

    function new();
      frame_pos = 0;
      byte_sum = '0;
      hdr_good = 0;
      low_sum_good = 0;
      cmd_byte = '0;
      len_byte = '0;
      mismatches = 0;
    endfunction

    function result_t make_result(status_e st, logic [7:0] cmd, logic [4:0] len,
                                  logic [7:0] data, logic [3:0] idx, logic present,
                                  logic closes);
      result_t r;
      r.status = st;
      r.command = cmd;
      r.length = len;
      r.data = data;
      r.index = idx;
      r.present = present;
      r.closes = closes;
      return r;
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    // Note one accepted word and queue the words it completes
    function void take_rx_byte(logic [7:0] rx, logic start);
      int unsigned pos;
      int unsigned len;
      int unsigned cnt;
      status_e     st;
      pos = start ? 0 : frame_pos;
      if (pos >= FRAME_BYTES) pos = 0;

      if (pos == 0) begin
        byte_sum = '0;
        hdr_good = (rx == HDR0);
      end else if (pos == 1) begin
        hdr_good = hdr_good && (rx == HDR1);
      end
      if (pos == CMD_POS) cmd_byte = rx;
      if (pos == LEN_POS) len_byte = rx;
      if (pos >= PAY_POS && pos - PAY_POS < PAYLOAD_MAX) payload_bytes[pos - PAY_POS] = rx;
      if (pos < FRAME_BYTES - 2) byte_sum = byte_sum + 16'(rx);
      if (pos == FRAME_BYTES - 2) low_sum_good = (rx == byte_sum[7:0]);

      if (pos != FRAME_BYTES - 1) begin
        frame_pos = pos + 1;
        return;
      end
      frame_pos = 0;

      // Header is judged before the sum
      if (!hdr_good) begin
        awaited_results.push_back(make_result(ST_HDR_ERR, '0, '0, '0, '0, 1'b0, 1'b1));
        return;
      end
      if (!low_sum_good || rx != byte_sum[15:8]) begin
        awaited_results.push_back(make_result(ST_SUM_ERR, '0, '0, '0, '0, 1'b0, 1'b1));
        return;
      end

      len = len_byte;
      st = ST_OK;
      if (len > PAYLOAD_MAX) begin
        len = PAYLOAD_MAX;
        st = ST_CLAMPED;
      end
      if (len == 0) begin
        awaited_results.push_back(make_result(st, cmd_byte, '0, '0, '0, 1'b0, 1'b1));
        return;
      end
      cnt = (len > MAX_OUT) ? MAX_OUT : len;
      for (int unsigned k = 0; k < cnt; k++) begin
        awaited_results.push_back(make_result(st, cmd_byte, 5'(len), payload_bytes[k],
                                              4'(k), 1'b1, k + 1 == cnt));
      end
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result word against the oldest expectation
    function void match_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing expected: status %0d command %0d index %0d",
               got.status, got.command, got.index);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare("status", 8'(want.status), 8'(got.status));
      compare("command", want.command, got.command);
      compare("payload_length", 8'(want.length), 8'(got.length));
      compare("payload_byte", want.data, got.data);
      compare("payload_index", 8'(want.index), 8'(got.index));
      compare("byte_present", 8'(want.present), 8'(got.present));
      compare("last", 8'(want.closes), 8'(got.closes));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       frame_start_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] status_o;
  logic [7:0] command_o;
  logic [4:0] payload_length_o;
  logic [7:0] payload_byte_o;
  logic [3:0] payload_index_o;
  logic       byte_present_o;
  logic       last_o;

  frame_result_board board;
  logic [7:0]  frame_buf [FRAME_BYTES];
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;

  fixed_frame_receive_checker #(
    .FRAME_BYTES(FRAME_BYTES),
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .command_o       (command_o),
    .payload_length_o(payload_length_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .byte_present_o  (byte_present_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL fixed_frame_receive_checker");
      $finish;
    end
  end

  // Recompute the little-endian sum over the summed bytes
  function void seal_frame();
    logic [15:0] s;
    s = '0;
    for (int unsigned i = 0; i < FRAME_BYTES - 2; i++) s = s + 16'(frame_buf[i]);
    frame_buf[FRAME_BYTES - 2] = s[7:0];
    frame_buf[FRAME_BYTES - 1] = s[15:8];
  endfunction

  // Fill a well-formed frame; a negative fill gives random content
  function void build_frame(logic [7:0] cmd, logic [7:0] len, int fill);
    for (int unsigned i = 0; i < FRAME_BYTES; i++)
      frame_buf[i] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
    frame_buf[0] = HDR0;
    frame_buf[1] = HDR1;
    frame_buf[CMD_POS] = cmd;
    frame_buf[LEN_POS] = len;
    seal_frame();
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(logic [7:0] b, logic s);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    frame_start_i <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.take_rx_byte(b, s);
    bytes_sent++;
  endtask

  task automatic send_frame(int unsigned n_bytes, bit use_start);
    if ($urandom_range(0, 5) == 0) tx_burst = !tx_burst;
    for (int unsigned i = 0; i < n_bytes; i++) send_word(frame_buf[i], (i == 0) && use_start);
  endtask

  // Drop valid and hold off until every queued result has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall a random while, then take one result word
  initial begin
    int unsigned hold;
    result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 8);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.status = status_e'(status_o);
      got.command = command_o;
      got.length = payload_length_o;
      got.data = payload_byte_o;
      got.index = payload_index_o;
      got.present = byte_present_o;
      got.closes = last_o;
      board.match_result(got);
    end
  end

  initial begin
    int unsigned goal;
    int unsigned kind;
    int unsigned n;
    int unsigned idx;
    bit          need_start;
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    frame_start_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty payload, all-zero bytes
    build_frame(8'h00, 8'd0, 0);
    send_frame(FRAME_BYTES, 1);
    // Full payload, all-ones bytes
    build_frame(8'hFF, 8'd16, 8'hFF);
    send_frame(FRAME_BYTES, 1);
    // Clamped lengths, just over and at the top
    build_frame(8'h3C, 8'd17, -1);
    send_frame(FRAME_BYTES, 1);
    build_frame(8'hC3, 8'd255, -1);
    send_frame(FRAME_BYTES, 1);
    // Single payload byte, next frame follows with no start flag
    build_frame(8'h81, 8'd1, -1);
    send_frame(FRAME_BYTES, 1);
    build_frame(8'h7E, 8'd9, -1);
    send_frame(FRAME_BYTES, 0);
    // Header errors on each header byte, sum kept good
    build_frame(8'h11, 8'd4, -1);
    frame_buf[0] = HDR1;
    seal_frame();
    send_frame(FRAME_BYTES, 1);
    build_frame(8'h22, 8'd4, -1);
    frame_buf[1] = HDR0;
    seal_frame();
    send_frame(FRAME_BYTES, 1);
    // Bad header and bad sum together: header wins
    build_frame(8'h33, 8'd4, -1);
    frame_buf[0] = 8'h00;
    frame_buf[FRAME_BYTES - 1] = ~frame_buf[FRAME_BYTES - 1];
    send_frame(FRAME_BYTES, 1);
    // Checksum errors on each sum byte
    build_frame(8'h44, 8'd8, -1);
    frame_buf[FRAME_BYTES - 2] = ~frame_buf[FRAME_BYTES - 2];
    send_frame(FRAME_BYTES, 1);
    build_frame(8'h55, 8'd8, -1);
    frame_buf[FRAME_BYTES - 1] = frame_buf[FRAME_BYTES - 1] ^ 8'h01;
    send_frame(FRAME_BYTES, 1);
    // Realign mid-frame and one word short of the end
    build_frame(8'h66, 8'd3, -1);
    send_frame(10, 1);
    build_frame(8'h77, 8'd16, -1);
    send_frame(FRAME_BYTES - 1, 1);
    build_frame(8'h88, 8'd12, -1);
    send_frame(FRAME_BYTES, 1);
    wait_drained();

    // Random frames: mostly well-formed, some damaged, truncated or noise
    goal = bytes_sent + RANDOM_BYTES;
    need_start = 1;
    while (bytes_sent < goal) begin
      kind = $urandom_range(0, 9);
      build_frame(8'($urandom_range(0, 255)),
                  ($urandom_range(0, 7) == 0) ? 8'($urandom_range(17, 255))
                                              : 8'($urandom_range(0, 16)), -1);
      case (kind)
        6: begin
          frame_buf[$urandom_range(0, 1)] = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 1) seal_frame();
        end
        7: begin
          idx = FRAME_BYTES - 2 + $urandom_range(0, 1);
          frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
        end
        default: ;
      endcase
      if (kind == 8) begin
        send_frame($urandom_range(1, FRAME_BYTES - 1), 1);
        need_start = 1;
      end else if (kind == 9) begin
        n = $urandom_range(1, 6);
        repeat (n) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        need_start = 1;
      end else begin
        send_frame(FRAME_BYTES, need_start || ($urandom_range(0, 3) != 0));
        need_start = 0;
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d expected result words never arrived", board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("PASS fixed_frame_receive_checker");
    end else begin
      $display("FAIL fixed_frame_receive_checker");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ffrc_pkg.sv
sv/ffrc_front.sv
sv/ffrc_queue.sv
sv/ffrc_back.sv
sv/fixed_frame_receive_checker.sv
bench/fixed_frame_receive_checker_tb.sv
